// ===== sv/assert_macros.svh =====
// Assertion macros used by modular_exponentiation_core.
// Depends on nothing; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== sv/modexp_pkg.sv =====
// Types and constants for the modular exponentiation core.
// No dependencies.
`default_nettype none
package modexp_pkg;
	localparam int unsigned MOD_BITS = 63;
	localparam int unsigned IN_BITS = 64;

	typedef logic [MOD_BITS-1:0] residue_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_LOAD = 3'd1,
		OP_REM_STEP = 3'd2,
		OP_FIX_NEG = 3'd3,
		OP_MUL_INIT = 3'd4,
		OP_MUL_STEP = 3'd5,
		OP_MUL_DONE = 3'd6,
		OP_NEXT_BIT = 3'd7
	} op_t;

	typedef struct packed {
		op_t op;
		logic mul_sq; // 1: square base, 0: result times base
	} dp_cmd_t;

	typedef struct packed {
		logic neg_exp;
		logic bit_set;
		logic next_set;
		logic last_bit;
		logic step_last;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/modular_exponentiation_core.sv =====
// Modular exponentiation core, right-to-left square and multiply.
// Setup is a check, a 64-step base remainder and a sign fix, then one or two multiplies
// per scanned exponent bit with an exponent shift between bits; exponent < 0 goes to output.
// One word at a time; the next is taken once the result word is taken.
// Multiplies are bit-serial shift-add and set the rate.
// Reset (arst_n low, asynchronous) returns the controller to idle.
`default_nettype none
module modular_exponentiation_core #(
	parameter int unsigned WORD_BITS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic ready,
	input wire logic [63:0] base,
	input wire logic [63:0] exponent,
	input wire logic [62:0] modulus,
	output logic power_valid,
	input wire logic power_ready,
	output logic [62:0] power
);
	import modexp_pkg::*;
	`include "assert_macros.svh"

	dp_cmd_t cmd;
	dp_stat_t stat;

	modexp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.power_valid(power_valid), .power_ready(power_ready),
		.stat(stat), .cmd(cmd)
	);

	modexp_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .cmd(cmd), .base(base),
		.exponent(exponent), .modulus(modulus), .stat(stat), .power(power)
	);

	`ASSERT_NEVER(a_no_both, clk, arst_n, ready && power_valid)
	`ASSERT_IMPL(a_accept_busy, clk, arst_n, (valid && ready) |=> !ready)
endmodule
`default_nettype wire

// ===== sv/modexp_datapath.sv =====
// Datapath: base remainder, shift-add modular multiplier, exponent shifter.
// Depends on modexp_pkg.
`default_nettype none
module modexp_datapath #(
	parameter int unsigned WORD_BITS = 64
) (
	input wire logic clk,
	input wire modexp_pkg::dp_cmd_t cmd,
	input wire logic [63:0] base,
	input wire logic [63:0] exponent,
	input wire logic [62:0] modulus,
	output modexp_pkg::dp_stat_t stat,
	output modexp_pkg::residue_t power
);
	import modexp_pkg::*;

	localparam int unsigned SCAN = (WORD_BITS < 63) ? WORD_BITS : 63;
	localparam int unsigned CW = $clog2(64);
	localparam int unsigned BW = $clog2(SCAN);

	residue_t m_q, b_q, r_q, acc_q, x_q;
	logic [63:0] y_q;
	logic [63:0] mag_q;
	logic [63:0] e_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] bit_q;
	logic [63:0] dbl;
	logic [63:0] sum;
	logic [63:0] rem_sh;
	residue_t acc_a, acc_b;

	// doubling then conditional add, each with one subtract of m
	always_comb begin
		dbl = {acc_q, 1'b0};
		acc_a = (dbl >= {1'b0, m_q}) ? 63'(dbl - {1'b0, m_q}) : dbl[62:0];
		sum = {1'b0, acc_a} + {1'b0, x_q};
		if (y_q[63])
			acc_b = (sum >= {1'b0, m_q}) ? 63'(sum - {1'b0, m_q}) : sum[62:0];
		else
			acc_b = acc_a;
		// restoring remainder: shift in next magnitude bit
		rem_sh = {acc_q, mag_q[63]};
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				m_q <= modulus;
				e_q <= exponent;
				neg_q <= base[63];
				mag_q <= base[63] ? (~base + 64'd1) : base;
				acc_q <= '0;
				cnt_q <= '0;
				bit_q <= '0;
				r_q <= (modulus == 63'd1) ? '0 : 63'd1;
			end
			OP_REM_STEP: begin
				acc_q <= (rem_sh >= {1'b0, m_q}) ? 63'(rem_sh - {1'b0, m_q})
					: rem_sh[62:0];
				mag_q <= {mag_q[62:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_FIX_NEG: begin
				b_q <= (neg_q && acc_q != '0) ? 63'(m_q - acc_q) : acc_q;
			end
			OP_MUL_INIT: begin
				acc_q <= '0;
				cnt_q <= '0;
				x_q <= cmd.mul_sq ? b_q : r_q;
				y_q <= {1'b0, b_q};
			end
			OP_MUL_STEP: begin
				acc_q <= acc_b;
				y_q <= {y_q[62:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_MUL_DONE: begin
				if (cmd.mul_sq)
					b_q <= acc_q;
				else
					r_q <= acc_q;
			end
			OP_NEXT_BIT: begin
				e_q <= {1'b0, e_q[63:1]};
				bit_q <= bit_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat.neg_exp = e_q[63];
	assign stat.bit_set = e_q[0];
	assign stat.next_set = e_q[1];
	assign stat.last_bit = (bit_q == BW'(SCAN - 1));
	assign stat.step_last = (cnt_q == CW'(63));
	assign power = r_q;
endmodule
`default_nettype wire

// ===== sv/modexp_ctrl.sv =====
// Controller state machine sequencing the datapath.
// Depends on modexp_pkg.
`default_nettype none
module modexp_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic ready,
	output logic power_valid,
	input wire logic power_ready,
	input wire modexp_pkg::dp_stat_t stat,
	output modexp_pkg::dp_cmd_t cmd
);
	import modexp_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b0_0000_0001,
		S_CHECK = 9'b0_0000_0010,
		S_REM = 9'b0_0000_0100,
		S_FIX = 9'b0_0000_1000,
		S_MINIT = 9'b0_0001_0000,
		S_MSTEP = 9'b0_0010_0000,
		S_MDONE = 9'b0_0100_0000,
		S_NEXT = 9'b0_1000_0000,
		S_OUT = 9'b1_0000_0000
	} state_t;

	state_t state_q;
	logic sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sq_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (valid) state_q <= S_CHECK;
				S_CHECK: state_q <= stat.neg_exp ? S_OUT : S_REM;
				S_REM: if (stat.step_last) state_q <= S_FIX;
				S_FIX: begin
					state_q <= S_MINIT;
					sq_q <= !stat.bit_set;
				end
				S_MINIT: state_q <= S_MSTEP;
				S_MSTEP: if (stat.step_last) state_q <= S_MDONE;
				S_MDONE: begin
					if (!sq_q) begin
						sq_q <= 1'b1;
						state_q <= S_MINIT;
					end else if (stat.last_bit) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_NEXT;
					end
				end
				// exponent shifts on this edge: decide on the bit above the current one
				S_NEXT: begin
					state_q <= S_MINIT;
					sq_q <= !stat.next_set;
				end
				S_OUT: if (power_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.mul_sq = sq_q;
		unique case (state_q)
			S_IDLE: cmd.op = valid ? OP_LOAD : OP_NONE;
			S_REM: cmd.op = OP_REM_STEP;
			S_FIX: cmd.op = OP_FIX_NEG;
			S_MINIT: cmd.op = OP_MUL_INIT;
			S_MSTEP: cmd.op = OP_MUL_STEP;
			S_MDONE: cmd.op = OP_MUL_DONE;
			S_NEXT: cmd.op = OP_NEXT_BIT;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign ready = (state_q == S_IDLE);
	assign power_valid = (state_q == S_OUT);
endmodule
`default_nettype wire

// ===== bench/tb_modular_exponentiation_core.sv =====
// Testbench for modular_exponentiation_core: square-and-multiply modular power.
// Depends on modexp_pkg and the core; predicts each power word and checks it in order.
`timescale 1ns / 1ps
`default_nettype none
module tb_modular_exponentiation_core;
	import modexp_pkg::*;

	localparam int unsigned SCAN_BITS = 64;
	localparam int unsigned STALL_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic [63:0] base = '0;
	logic [63:0] exponent = '0;
	logic [62:0] modulus = 63'd1;
	logic power_valid;
	logic power_ready = 1'b0;
	logic [62:0] power;

	residue_t power_queue[$];
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned out_wait = 0;
	bit sending_done = 1'b0;

	modular_exponentiation_core #(.WORD_BITS(SCAN_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.base(base), .exponent(exponent), .modulus(modulus),
		.power_valid(power_valid), .power_ready(power_ready), .power(power)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// exact (x * y) mod m, with x, y < m < 2^63
	function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
		logic [127:0] prod;
		prod = x * y;
		return 64'(prod % m);
	endfunction

	function automatic residue_t predict_power(logic [63:0] b_raw, logic [63:0] e,
			logic [62:0] m_in);
		logic [63:0] m, b, r, mag, rem;
		m = {1'b0, m_in};
		if (m == 0)
			return '0;
		r = 64'd1 % m;
		if (e[63])
			return r[62:0];
		if (!b_raw[63]) begin
			b = b_raw % m;
		end else begin
			mag = (~b_raw) + 64'd1;
			rem = mag % m;
			b = (rem == 0) ? 64'd0 : m - rem;
		end
		for (int i = 0; i < SCAN_BITS && i < 63; i++) begin
			if (e[i])
				r = mul_mod(r, b, m);
			b = mul_mod(b, b, m);
		end
		return r[62:0];
	endfunction

	// valid drops only when a gap follows, so back-to-back words keep it high
	task automatic send_word(logic [63:0] b, logic [63:0] e, logic [62:0] m);
		int unsigned gap;
		gap = $urandom_range(0, 14);
		if (gap != 0) begin
			valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		base <= b;
		exponent <= e;
		modulus <= m;
		valid <= 1'b1;
		do @(posedge clk); while (!ready);
		power_queue.push_back(predict_power(b, e, m));
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly short exponents keep the run short; a few full-width ones
	function automatic logic [63:0] rand_exponent();
		case ($urandom_range(0, 9))
			0: return rand64();
			1: return rand64() & 64'h7FFF_FFFF_FFFF_FFFF;
			2, 3: return {56'd0, 8'($urandom())};
			default: return {48'd0, 16'($urandom())};
		endcase
	endfunction

	function automatic logic [62:0] rand_modulus();
		logic [62:0] m;
		logic [63:0] raw;
		raw = rand64();
		case ($urandom_range(0, 4))
			0: m = 63'($urandom_range(1, 20));
			1: m = 63'($urandom());
			default: m = raw[62:0];
		endcase
		return (m == 0) ? 63'd1 : m;
	endfunction

	task automatic wait_drained();
		valid <= 1'b0;
		while (power_queue.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_extremes();
		logic [63:0] min_s, max_s;
		logic [62:0] max_m;
		min_s = 64'h8000_0000_0000_0000;
		max_s = 64'h7FFF_FFFF_FFFF_FFFF;
		max_m = '1;
		send_word(min_s, 64'd3, max_m);
		send_word(max_s, 64'd5, max_m);
		send_word(max_s, max_s, max_m);
		send_word(min_s, max_s, 63'd1_000_000_007);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd7, max_m);
		send_word(64'd0, 64'd0, max_m);
		send_word(64'd0, 64'd9, 63'd13);
		send_word(max_s, 64'd1, 63'd2);
		send_word(min_s, 64'd2, 63'd3);
	endtask

	task automatic test_negative_exponent();
		send_word(64'd12345, 64'h8000_0000_0000_0000, 63'd97);
		send_word(64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, '1);
		send_word(64'd5, 64'hFFFF_FFFF_FFFF_FFFE, 63'd1);
	endtask

	task automatic test_modulus_one();
		send_word(64'd77, 64'd10, 63'd1);
		send_word(64'h8000_0000_0000_0000, 64'd0, 63'd1);
		send_word(64'hDEAD_BEEF_1234_5678, 64'h7FFF_FFFF_FFFF_FFFF, 63'd1);
	endtask

	task automatic test_small_cases();
		send_word(64'd2, 64'd10, 63'd1000);
		send_word(-64'sd2, 64'd3, 63'd7);
		send_word(-64'sd7, 64'd2, 63'd7);
		send_word(64'd3, 64'd200, 63'd1_000_000_007);
	endtask

	task automatic test_random(int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			send_word(rand64(), rand_exponent(), rand_modulus());
			// hold off once until the core has drained
			if (n == count / 2)
				wait_drained();
		end
	endtask

	// draw a fresh wait per result word; raise ready once it runs out
	always @(negedge clk) begin
		if (!arst_n || !power_valid) begin
			power_ready <= 1'b0;
			out_wait <= $urandom_range(0, 14);
		end else if (out_wait == 0) begin
			power_ready <= 1'b1;
		end else begin
			out_wait <= out_wait - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && power_valid && power_ready) begin
			if (power_queue.size() == 0) begin
				$error("unexpected power word %0h", power);
				error_count++;
			end else begin
				residue_t want;
				want = power_queue.pop_front();
				if (power !== want) begin
					$error("power: expected %0h actual %0h", want, power);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((valid && ready) || (power_valid && power_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("modular_exponentiation_core regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_negative_exponent();
		test_modulus_one();
		test_small_cases();
		test_random(85);
		wait_drained();
		repeat (9000) @(negedge clk);
		if (error_count == 0 && power_queue.size() == 0)
			$display("modular_exponentiation_core regression: pass");
		else
			$display("modular_exponentiation_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
